FILE: rtl/pbs_pkg.sv
`timescale 1ns / 1ps

package pbs_pkg;

  // sizes
  localparam int THREAD_COUNT  = 32;
  localparam int TIMEOUT_WIDTH = 32;
  localparam int PRIO_W        = 6;
  localparam int PRES_W        = THREAD_COUNT + 1;
  localparam int IDX_W         = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int PRES_IDX_W    = $clog2(PRES_W);

  // request codes
  localparam logic [1:0] FN_REGISTER = 2'd0;
  localparam logic [1:0] FN_DELAY    = 2'd1;
  localparam logic [1:0] FN_TICK     = 2'd2;
  localparam logic [1:0] FN_SCHEDULE = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TAKEN      = 2'd1;
  localparam logic [1:0] ST_IDLE_DELAY = 2'd2;
  localparam logic [1:0] ST_ZERO_DELAY = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  priority_req;
    logic [31:0] ticks;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]  next_priority;
    logic        switch_request;
    logic [1:0]  status;
    logic [31:0] ready_mask;
    logic [31:0] waiting_mask;
  } out_beat_t;

  // sweep token handed from cell to cell, top priority first
  typedef struct packed {
    logic              active;
    logic              tick;
    logic              found;
    logic [PRIO_W-1:0] pos;
    logic [PRIO_W-1:0] pick;
  } token_t;

  // per-cell writes made in the accept cycle
  typedef struct packed {
    logic                     set_ready;
    logic                     park;
    logic [TIMEOUT_WIDTH-1:0] ticks;
  } cell_ctl_t;

endpackage

FILE: rtl/pbs_cell.sv
`timescale 1ns / 1ps

module pbs_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  pbs_pkg::token_t    tok_i,
  input  pbs_pkg::cell_ctl_t ctl_i,
  output pbs_pkg::token_t    tok_o,
  output logic               ready_o,
  output logic               delayed_o
);

  logic                              ready_r, ready_nxt;
  logic                              delayed_r, delayed_nxt;
  logic [pbs_pkg::TIMEOUT_WIDTH-1:0] count_r, count_nxt;
  pbs_pkg::token_t                   tok_r, tok_nxt;

  // update own thread slot and pass the token down
  always_comb begin
    ready_nxt   = ready_r;
    delayed_nxt = delayed_r;
    count_nxt   = count_r;
    tok_nxt     = tok_i;
    tok_nxt.pos = tok_i.pos - pbs_pkg::PRIO_W'(1);
    if (ctl_i.set_ready) begin
      ready_nxt = 1'b1;
    end
    if (ctl_i.park) begin
      count_nxt   = ctl_i.ticks;
      ready_nxt   = 1'b0;
      delayed_nxt = 1'b1;
    end
    if (tok_i.active) begin
      if (tok_i.tick) begin
        // count down; wake on expiry
        if (delayed_r) begin
          if (count_r <= pbs_pkg::TIMEOUT_WIDTH'(1)) begin
            count_nxt   = '0;
            ready_nxt   = 1'b1;
            delayed_nxt = 1'b0;
          end else begin
            count_nxt = count_r - pbs_pkg::TIMEOUT_WIDTH'(1);
          end
        end
      end else if (!tok_i.found && ready_r) begin
        // first ready slot from the top wins
        tok_nxt.found = 1'b1;
        tok_nxt.pick  = tok_i.pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r   <= 1'b0;
      delayed_r <= 1'b0;
      tok_r     <= '0;
    end else begin
      ready_r   <= ready_nxt;
      delayed_r <= delayed_nxt;
      tok_r     <= tok_nxt;
    end
  end

  // counter holds no reset value
  always_ff @(posedge clk) begin
    count_r <= count_nxt;
  end

  assign tok_o     = tok_r;
  assign ready_o   = ready_r;
  assign delayed_o = delayed_r;

endmodule

FILE: rtl/priority_bitmap_thread_scheduler_top.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake          | Beat
// in_     | input     | in_valid/in_stall   | pbs_pkg::in_beat_t (func, priority_req, ticks)
// out_    | output    | out_valid/out_stall | pbs_pkg::out_beat_t (one beat per input beat)
//
// Every request sends one token down the row of 32 priority cells, one cell per cycle,
// so the input takes no new beat until the result of the last one is loaded.
// Tick countdowns and the schedule search both ride the token through the cell row.
// Reset (rst_n low, synchronous) clears all bitmaps, the current thread and the token row.
// A stalled result holds in the output register; the finished token waits in the
// finish register, and in_stall stays high until the result is loaded.

module priority_bitmap_thread_scheduler_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pbs_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pbs_pkg::out_beat_t out_data
);

  localparam int TC = pbs_pkg::THREAD_COUNT;

  logic                           busy_r;
  logic [pbs_pkg::PRES_W-1:0]     present_r;
  logic [pbs_pkg::PRIO_W-1:0]     cur_prio_r;
  logic                           cur_valid_r;
  pbs_pkg::token_t                start_r;
  logic [1:0]                     op_func_r;
  logic [1:0]                     op_status_r;
  pbs_pkg::token_t                fin_r;
  logic                           fin_v_r;
  logic                           out_valid_r;
  pbs_pkg::out_beat_t             out_data_r;

  logic                              accept;
  logic                              load;
  logic [pbs_pkg::TIMEOUT_WIDTH-1:0] ticks_m;
  logic                              prio_ok;
  logic                              taken;
  logic [pbs_pkg::PRES_IDX_W-1:0]    pres_idx;
  logic [pbs_pkg::IDX_W-1:0]         reg_idx;
  logic [pbs_pkg::IDX_W-1:0]         cur_idx;
  logic [1:0]                        status;
  logic                              reg_ok;
  logic                              park_ok;
  pbs_pkg::cell_ctl_t                ctl [TC];
  pbs_pkg::token_t                   chain [TC+1];
  logic [TC-1:0]                     ready_vec;
  logic [TC-1:0]                     delayed_vec;
  logic [TC:0]                       tok_act;
  logic                              pick_valid;
  logic [pbs_pkg::PRIO_W-1:0]        pick;
  logic                              sched_op;
  logic                              differs;
  pbs_pkg::out_beat_t                res;

  assign accept   = in_valid && !busy_r;
  assign in_stall = busy_r;
  assign load     = fin_v_r && (!out_valid_r || !out_stall);

  // decode the request against the current state
  always_comb begin
    ticks_m  = in_data.ticks[pbs_pkg::TIMEOUT_WIDTH-1:0];
    prio_ok  = in_data.priority_req <= pbs_pkg::PRIO_W'(TC);
    pres_idx = pbs_pkg::PRES_IDX_W'(in_data.priority_req);
    taken    = !prio_ok || present_r[pres_idx];
    reg_idx  = pbs_pkg::IDX_W'(in_data.priority_req - pbs_pkg::PRIO_W'(1));
    cur_idx  = pbs_pkg::IDX_W'(cur_prio_r - pbs_pkg::PRIO_W'(1));
    status   = pbs_pkg::ST_OK;
    case (in_data.func)
      pbs_pkg::FN_REGISTER: begin
        if (taken) status = pbs_pkg::ST_TAKEN;
      end
      pbs_pkg::FN_DELAY: begin
        if (!cur_valid_r || cur_prio_r == '0) status = pbs_pkg::ST_IDLE_DELAY;
        else if (ticks_m == '0) status = pbs_pkg::ST_ZERO_DELAY;
      end
      default: status = pbs_pkg::ST_OK;
    endcase
    reg_ok  = accept && in_data.func == pbs_pkg::FN_REGISTER && status == pbs_pkg::ST_OK;
    park_ok = accept && in_data.func == pbs_pkg::FN_DELAY && status == pbs_pkg::ST_OK;
  end

  // build the cell row
  assign chain[TC] = start_r;
  assign tok_act[TC] = start_r.active;

  for (genvar k = 0; k < TC; k++) begin : g_cell
    always_comb begin
      ctl[k].set_ready = reg_ok && in_data.priority_req != '0 &&
                         reg_idx == pbs_pkg::IDX_W'(k);
      ctl[k].park      = park_ok && cur_idx == pbs_pkg::IDX_W'(k);
      ctl[k].ticks     = ticks_m;
    end

    pbs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_i     (chain[k+1]),
      .ctl_i     (ctl[k]),
      .tok_o     (chain[k]),
      .ready_o   (ready_vec[k]),
      .delayed_o (delayed_vec[k])
    );

    assign tok_act[k] = chain[k].active;
  end

  // resolve the pick once the token leaves the bottom cell
  always_comb begin
    pick_valid = fin_r.found || present_r[0];
    pick       = fin_r.found ? fin_r.pick : '0;
    sched_op   = op_func_r == pbs_pkg::FN_SCHEDULE ||
                 (op_func_r == pbs_pkg::FN_DELAY && op_status_r == pbs_pkg::ST_OK);
    differs    = (pick_valid != cur_valid_r) || (pick_valid && pick != cur_prio_r);
    res.next_priority  = sched_op ? pick : cur_prio_r;
    res.switch_request = sched_op && differs;
    res.status         = op_status_r;
    res.ready_mask     = 32'(ready_vec);
    res.waiting_mask   = 32'(delayed_vec);
  end

  // control, bitmaps and current thread
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      present_r   <= '0;
      cur_prio_r  <= '0;
      cur_valid_r <= 1'b0;
      start_r     <= '0;
      fin_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r.active <= accept;
      if (accept) begin
        busy_r         <= 1'b1;
        start_r.tick   <= in_data.func == pbs_pkg::FN_TICK;
        start_r.found  <= 1'b0;
        start_r.pos    <= pbs_pkg::PRIO_W'(TC);
        start_r.pick   <= '0;
        if (reg_ok) present_r[pres_idx] <= 1'b1;
      end
      if (chain[0].active) begin
        fin_v_r <= 1'b1;
      end else if (load) begin
        fin_v_r <= 1'b0;
      end
      if (load) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
        if (sched_op && differs) begin
          cur_prio_r  <= pick;
          cur_valid_r <= pick_valid;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_func_r   <= in_data.func;
      op_status_r <= status;
    end
    if (chain[0].active) fin_r <= chain[0];
    if (load) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a thread is never ready and delayed at once
  a_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (ready_vec & delayed_vec) == '0)
    else $error("ready and delayed overlap");

  // at most one token in flight, finish register included
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({tok_act, fin_v_r}))
    else $error("more than one sweep token");

  // an accepted beat starts a sweep and blocks the input
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && start_r.active)
    else $error("sweep not started");

  // nothing moves in the row while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (tok_act == '0) && !fin_v_r)
    else $error("token active while idle");

endmodule

FILE: test/priority_bitmap_thread_scheduler_top_test.sv
`timescale 1ns / 1ps

module priority_bitmap_thread_scheduler_top_test;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  pbs_pkg::in_beat_t  in_data;
  logic               out_valid;
  logic               out_stall;
  pbs_pkg::out_beat_t out_data;

  priority_bitmap_thread_scheduler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // scheduler state as the testbench tracks it
  logic [31:0] sched_ready;
  logic [31:0] sched_delayed;
  logic [32:0] sched_present;
  logic [31:0] sched_timeout [32];
  logic [5:0]  sched_cur;
  logic        sched_cur_valid;

  pbs_pkg::in_beat_t  request_q [$];
  pbs_pkg::out_beat_t grant_q [$];

  int error_count;
  int grants_seen;
  int burst_left;
  int gap_left;
  int hold_left;
  bit hold_done;
  int stall_mode;
  int seg_left;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Pick the highest ready priority, or idle; take the pick as current on a switch.
  function automatic void choose_thread(output logic [5:0] nxt, output logic sw);
    logic [5:0] pick;
    logic       pick_ok;
    pick = '0;
    if (sched_ready != '0) begin
      for (int i = 31; i >= 0; i--) begin
        if (sched_ready[i]) begin
          pick = 6'(i + 1);
          break;
        end
      end
      pick_ok = 1'b1;
    end else begin
      pick_ok = sched_present[0];
    end
    if (pick_ok != sched_cur_valid || (pick_ok && pick != sched_cur)) begin
      sw              = 1'b1;
      sched_cur       = pick;
      sched_cur_valid = pick_ok;
    end else begin
      sw = 1'b0;
    end
    nxt = pick;
  endfunction

  // Apply one request to the tracked state and return the grant it produces.
  function automatic pbs_pkg::out_beat_t schedule_grant(pbs_pkg::in_beat_t req);
    pbs_pkg::out_beat_t g;
    logic [4:0]         idx;
    g.next_priority  = sched_cur;
    g.switch_request = 1'b0;
    g.status         = pbs_pkg::ST_OK;
    case (req.func)
      pbs_pkg::FN_REGISTER: begin
        if (req.priority_req > pbs_pkg::THREAD_COUNT) begin
          g.status = pbs_pkg::ST_TAKEN;
        end else if (sched_present[req.priority_req]) begin
          g.status = pbs_pkg::ST_TAKEN;
        end else begin
          sched_present[req.priority_req] = 1'b1;
          if (req.priority_req != 0) sched_ready[req.priority_req - 1] = 1'b1;
        end
      end
      pbs_pkg::FN_DELAY: begin
        if (!sched_cur_valid || sched_cur == 0) begin
          g.status = pbs_pkg::ST_IDLE_DELAY;
        end else if (req.ticks == '0) begin
          g.status = pbs_pkg::ST_ZERO_DELAY;
        end else begin
          idx                = 5'(sched_cur - 1);
          sched_timeout[idx] = req.ticks;
          sched_ready[idx]   = 1'b0;
          sched_delayed[idx] = 1'b1;
          choose_thread(g.next_priority, g.switch_request);
        end
      end
      pbs_pkg::FN_TICK: begin
        for (int i = 0; i < 32; i++) begin
          if (sched_delayed[i]) begin
            if (sched_timeout[i] <= 1) begin
              sched_timeout[i] = '0;
              sched_ready[i]   = 1'b1;
              sched_delayed[i] = 1'b0;
            end else begin
              sched_timeout[i] = sched_timeout[i] - 1;
            end
          end
        end
      end
      default: begin
        choose_thread(g.next_priority, g.switch_request);
      end
    endcase
    g.ready_mask   = sched_ready;
    g.waiting_mask = sched_delayed;
    return g;
  endfunction

  function automatic void add_request(logic [1:0] fn, logic [5:0] prio, logic [31:0] ticks);
    pbs_pkg::in_beat_t r;
    r.func         = fn;
    r.priority_req = prio;
    r.ticks        = ticks;
    request_q.push_back(r);
  endfunction

  // Mostly delays and ticks with short counts so threads cycle through parked and ready.
  function automatic pbs_pkg::in_beat_t random_request();
    pbs_pkg::in_beat_t r;
    int                u;
    u              = $urandom_range(0, 99);
    r.priority_req = 6'($urandom);
    r.ticks        = $urandom;
    if (u < 12) begin
      r.func = pbs_pkg::FN_REGISTER;
      r.priority_req = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 32))
                                                    : 6'($urandom_range(33, 63));
    end else if (u < 42) begin
      r.func = pbs_pkg::FN_DELAY;
      u      = $urandom_range(0, 99);
      if (u < 3) r.ticks = '0;
      else if (u < 5) r.ticks = $urandom;
      else r.ticks = $urandom_range(1, 8);
    end else if (u < 77) begin
      r.func = pbs_pkg::FN_TICK;
    end else begin
      r.func = pbs_pkg::FN_SCHEDULE;
    end
    return r;
  endfunction

  // Driver: send queued requests in bursts separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= $urandom_range(1, 20);
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) grant_q.push_back(schedule_grant(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= request_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 45);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Hold the output off for a long stretch once, after a few hundred grants.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && grants_seen >= 300) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each grant beat against the oldest expected one, then pick the next stall.
  always @(posedge clk) begin : monitor
    pbs_pkg::out_beat_t exp_beat;
    logic               stall_bit;
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_mode  <= 0;
      seg_left    <= 0;
      cycle_count <= 0;
      grants_seen <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (out_valid && !out_stall) begin
        grants_seen <= grants_seen + 1;
        if (grant_q.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= 10)
            $display("unexpected grant beat: %p", out_data);
        end else begin
          exp_beat = grant_q.pop_front();
          if (out_data.next_priority  !== exp_beat.next_priority  ||
              out_data.switch_request !== exp_beat.switch_request ||
              out_data.status         !== exp_beat.status         ||
              out_data.ready_mask     !== exp_beat.ready_mask     ||
              out_data.waiting_mask   !== exp_beat.waiting_mask) begin
            error_count = error_count + 1;
            if (error_count <= 10)
              $display("grant mismatch: expected %p, got %p", exp_beat, out_data);
          end
        end
      end
      if (seg_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        seg_left   <= $urandom_range(20, 200);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (stall_mode)
        0:       stall_bit = 1'b0;
        1:       stall_bit = 1'($urandom_range(0, 1));
        2:       stall_bit = ($urandom_range(0, 99) < 85);
        default: stall_bit = (cycle_count % 4 != 0);
      endcase
      out_stall <= (hold_left != 0) || stall_bit;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_stall       = 1'b0;
    error_count     = 0;
    sched_ready     = '0;
    sched_delayed   = '0;
    sched_present   = '0;
    sched_cur       = '0;
    sched_cur_valid = 1'b0;
    for (int i = 0; i < 32; i++) sched_timeout[i] = '0;

    // no thread present yet: empty schedule, delay with nothing running
    add_request(pbs_pkg::FN_SCHEDULE, 6'd0, 32'h0);
    add_request(pbs_pkg::FN_DELAY, 6'd0, 32'd4);
    // a lone thread parks with idle absent, so nothing runs
    add_request(pbs_pkg::FN_REGISTER, 6'd5, 32'h0);
    add_request(pbs_pkg::FN_SCHEDULE, 6'd0, 32'h0);
    add_request(pbs_pkg::FN_DELAY, 6'd0, 32'd1);
    add_request(pbs_pkg::FN_TICK, 6'd0, 32'h0);
    // idle, top priority, out of range and taken registrations
    add_request(pbs_pkg::FN_REGISTER, 6'd0, 32'hFFFF_FFFF);
    add_request(pbs_pkg::FN_REGISTER, 6'd32, 32'h0);
    add_request(pbs_pkg::FN_REGISTER, 6'd33, 32'h0);
    add_request(pbs_pkg::FN_REGISTER, 6'd63, 32'h0);
    add_request(pbs_pkg::FN_REGISTER, 6'd32, 32'h0);
    add_request(pbs_pkg::FN_REGISTER, 6'd0, 32'h0);
    add_request(pbs_pkg::FN_REGISTER, 6'd1, 32'h0);
    add_request(pbs_pkg::FN_SCHEDULE, 6'd0, 32'h0);
    // zero delay, longest delay, then park down to idle
    add_request(pbs_pkg::FN_DELAY, 6'd0, 32'h0);
    add_request(pbs_pkg::FN_DELAY, 6'd0, 32'hFFFF_FFFF);
    add_request(pbs_pkg::FN_DELAY, 6'd0, 32'd3);
    add_request(pbs_pkg::FN_DELAY, 6'd0, 32'd2);
    add_request(pbs_pkg::FN_DELAY, 6'd0, 32'd2);
    add_request(pbs_pkg::FN_SCHEDULE, 6'd0, 32'h0);
    add_request(pbs_pkg::FN_TICK, 6'd0, 32'h0);
    add_request(pbs_pkg::FN_TICK, 6'd0, 32'h0);
    add_request(pbs_pkg::FN_TICK, 6'd0, 32'h0);
    add_request(pbs_pkg::FN_SCHEDULE, 6'd0, 32'h0);
    for (int n = 0; n < 1200; n++) request_q.push_back(random_request());

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // drain stimulus, then expected grants, then let the pipeline settle
    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (grant_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("priority_bitmap_thread_scheduler_top test passed");
    end else begin
      $display("priority_bitmap_thread_scheduler_top test failed");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #20000000;
    $display("priority_bitmap_thread_scheduler_top test failed");
    $finish;
  end

endmodule
